FILE: sv/servo_status_packet_receiver_macros.svh
// Assertion macros used by the checker of the servo status packet receiver.
`ifndef SERVO_STATUS_PACKET_RECEIVER_MACROS_SVH
`define SERVO_STATUS_PACKET_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSR_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SSR_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: sv/ssr_pkg.sv
// Types and constants of the servo status packet receiver.
package ssr_pkg;

	localparam int ByteW = 8;

	// Input operation codes.
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	// Result status codes.
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_TIMEOUT    = 3'd1;
	localparam logic [2:0] ST_BAD_LENGTH = 3'd2;
	localparam logic [2:0] ST_CHECKSUM   = 3'd3;
	localparam logic [2:0] ST_ID         = 3'd4;
	localparam logic [2:0] ST_SERVO_ERR  = 3'd5;

	// Configuration register indexes.
	localparam logic [1:0] REG_EXPECTED_ID = 2'd0;
	localparam logic [1:0] REG_RETRY_LIMIT = 2'd1;
	localparam logic [1:0] REG_MAX_LENGTH  = 2'd2;

	localparam logic [ByteW-1:0] HEADER_BYTE     = 8'hFF;
	localparam logic [ByteW-1:0] RST_EXPECTED_ID = 8'd1;
	localparam logic [ByteW-1:0] RST_RETRY_LIMIT = 8'd200;
	localparam logic [ByteW-1:0] RST_MAX_LENGTH  = 8'd64;
	localparam logic [ByteW-1:0] MIN_LENGTH      = 8'd2;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_HDR1  = 3'd1,
		PH_HDR2  = 3'd2,
		PH_ID    = 3'd3,
		PH_LEN   = 3'd4,
		PH_ERR   = 3'd5,
		PH_PARAM = 3'd6,
		PH_SUM   = 3'd7
	} phase_t;

	typedef struct packed {
		logic [ByteW-1:0] expected_id;
		logic [ByteW-1:0] retry_limit;
		logic [ByteW-1:0] max_length;
	} cfg_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [ByteW-1:0] resp_id;
		logic [ByteW-1:0] servo_error;
		logic [ByteW-1:0] param_count;
		logic [15:0]      value;
	} res_t;

endpackage

FILE: sv/ssr_cfg_regs.sv
// Configuration registers of the servo status packet receiver.
module ssr_cfg_regs import ssr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [1:0]       wr_index,
	input  logic [ByteW-1:0] wr_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_id <= RST_EXPECTED_ID;
			cfg_q.retry_limit <= RST_RETRY_LIMIT;
			cfg_q.max_length  <= RST_MAX_LENGTH;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_EXPECTED_ID: cfg_q.expected_id <= wr_data;
				REG_RETRY_LIMIT: cfg_q.retry_limit <= wr_data;
				REG_MAX_LENGTH:  cfg_q.max_length  <= wr_data;
				default: ; // Writes beyond the register list are dropped.
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: sv/ssr_parser.sv
// Packet parser: state registers, per-word next-state logic and result formation.
module ssr_parser import ssr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             word_valid,
	input  logic             fire,
	input  logic [1:0]       op,
	input  logic [ByteW-1:0] rx,
	output logic             res_valid,
	output res_t             res
);

	phase_t           phase_q, phase_d;
	logic [ByteW-1:0] wait_count_q, wait_count_d;
	logic [ByteW-1:0] got_id_q, got_id_d;
	logic [ByteW-1:0] got_length_q, got_length_d;
	logic [ByteW-1:0] got_error_q, got_error_d;
	logic [ByteW-1:0] param_index_q, param_index_d;
	logic [ByteW-1:0] running_sum_q, running_sum_d;
	logic [15:0]      param_value_q, param_value_d;

	logic             is_start, active, is_tick, is_byte;
	logic [ByteW:0]   wait_inc;
	logic             tick_over, len_bad, last_param;
	logic [ByteW-1:0] param_index_inc;
	logic [ByteW-1:0] sum_plus_rx;

	assign is_start  = word_valid && (op == OP_START);
	assign active    = word_valid && (phase_q != PH_IDLE) && (op != OP_START)
		&& (op != OP_NONE);
	assign is_tick   = active && (op == OP_TICK);
	assign is_byte   = active && (op == OP_BYTE);
	assign wait_inc  = {1'b0, wait_count_q} + {{ByteW{1'b0}}, 1'b1};
	assign tick_over = wait_inc > {1'b0, cfg.retry_limit};
	assign len_bad   = (rx < MIN_LENGTH) || (rx > cfg.max_length);
	assign param_index_inc = param_index_q + 8'd1;
	// The packet ends once parameter count plus two reaches the length byte.
	assign last_param = ({1'b0, param_index_inc} + 9'd2) >= {1'b0, got_length_q};
	assign sum_plus_rx = running_sum_q + rx;

	// A result is due on a timeout, a bad length byte or the checksum byte.
	always_comb begin
		res_valid = 1'b0;
		if (is_tick && tick_over)
			res_valid = 1'b1;
		else if (is_byte && (phase_q == PH_LEN) && len_bad)
			res_valid = 1'b1;
		else if (is_byte && (phase_q == PH_SUM))
			res_valid = 1'b1;
	end

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (is_start) begin
			phase_d = PH_HDR1;
		end else if (res_valid) begin
			phase_d = PH_IDLE;
		end else if (is_byte) begin
			unique case (phase_q)
				PH_IDLE:  phase_d = PH_IDLE;
				PH_HDR1:  phase_d = (rx == HEADER_BYTE) ? PH_HDR2 : PH_HDR1;
				PH_HDR2:  phase_d = (rx == HEADER_BYTE) ? PH_ID : PH_HDR1;
				PH_ID:    phase_d = PH_LEN;
				PH_LEN:   phase_d = PH_ERR;
				PH_ERR:   phase_d = (got_length_q == MIN_LENGTH) ? PH_SUM : PH_PARAM;
				PH_PARAM: phase_d = last_param ? PH_SUM : PH_PARAM;
				PH_SUM:   phase_d = PH_IDLE;
			endcase
		end
	end

	// Captured fields and result.
	always_comb begin
		wait_count_d  = wait_count_q;
		got_id_d      = got_id_q;
		got_length_d  = got_length_q;
		got_error_d   = got_error_q;
		param_index_d = param_index_q;
		running_sum_d = running_sum_q;
		param_value_d = param_value_q;
		if (is_start) begin
			wait_count_d  = '0;
			got_id_d      = '0;
			got_length_d  = '0;
			got_error_d   = '0;
			param_index_d = '0;
			running_sum_d = '0;
			param_value_d = '0;
		end else if (is_tick && !tick_over) begin
			wait_count_d = wait_inc[ByteW-1:0];
		end else if (is_byte) begin
			unique case (phase_q)
				PH_ID: begin
					got_id_d      = rx;
					running_sum_d = rx;
				end
				PH_LEN: begin
					got_length_d = rx;
					if (!len_bad) begin
						running_sum_d = sum_plus_rx;
						wait_count_d  = '0;
					end
				end
				PH_ERR: begin
					got_error_d   = rx;
					running_sum_d = sum_plus_rx;
				end
				PH_PARAM: begin
					if (param_index_q == 8'd0)
						param_value_d = {param_value_q[15:8], rx};
					else if (param_index_q == 8'd1)
						param_value_d = {rx, param_value_q[7:0]};
					running_sum_d = sum_plus_rx;
					param_index_d = param_index_inc;
				end
				default: ;
			endcase
		end

		res.resp_id     = got_id_q;
		res.servo_error = got_error_q;
		res.param_count = param_index_q;
		res.value       = param_value_q;
		if (is_tick)
			res.status = ST_TIMEOUT;
		else if (phase_q == PH_LEN)
			res.status = ST_BAD_LENGTH;
		else if (~running_sum_q != rx)
			res.status = ST_CHECKSUM;
		else if (got_id_q != cfg.expected_id)
			res.status = ST_ID;
		else if (got_error_q != 8'd0)
			res.status = ST_SERVO_ERR;
		else
			res.status = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			wait_count_q  <= '0;
			got_id_q      <= '0;
			got_length_q  <= '0;
			got_error_q   <= '0;
			param_index_q <= '0;
			running_sum_q <= '0;
			param_value_q <= '0;
		end else if (fire) begin
			phase_q       <= phase_d;
			wait_count_q  <= wait_count_d;
			got_id_q      <= got_id_d;
			got_length_q  <= got_length_d;
			got_error_q   <= got_error_d;
			param_index_q <= param_index_d;
			running_sum_q <= running_sum_d;
			param_value_q <= param_value_d;
		end
	end

endmodule

FILE: sv/servo_status_packet_receiver.sv
// Top level of the servo status packet receiver.
//
// The block parses one status packet from a half-duplex smart-servo bus.
// Each input word carries an operation and a byte: a start word arms the
// receiver, byte words feed the packet (two 0xFF header bytes, id, length,
// error byte, parameters and an inverted 8-bit sum checksum), and tick words
// count waiting time against the retry limit.
// One result word is produced per finished packet, carrying a status code,
// the id, the error byte, the parameter count and the first two parameters.
// A word is registered on acceptance and its result, if any, is registered
// in the output register when the word moves on. The block takes one word per
// cycle unless a waiting result stalls it, as the parser updates its state for
// each word.
// When the output is stalled with a result waiting, the input register still
// drains words that cause no result; a word that would cause one holds until
// the output register is free, and the input then stalls behind it.
// Reset clears the receiver to idle and loads the register defaults
// (expected id 1, retry limit 200, largest length 64). Configuration
// writes are taken at once and should only be issued while idle.
module servo_status_packet_receiver import ssr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// Input channel.
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       operation,
	input  logic [ByteW-1:0] rx_byte,
	// Result channel.
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       status,
	output logic [ByteW-1:0] resp_id,
	output logic [ByteW-1:0] servo_error,
	output logic [ByteW-1:0] param_count,
	output logic [15:0]      value,
	// Configuration write channel.
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [ByteW-1:0] cfg_data
);

	cfg_t             cfg;
	logic             v_s1;
	logic [1:0]       op_s1;
	logic [ByteW-1:0] byte_s1;
	logic             res_valid;
	res_t             res;
	logic             out_valid_q;
	res_t             out_q;
	logic             advance;

	// The registers take every write straight away.
	assign cfg_ready = 1'b1;

	ssr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The registered word moves on unless it makes a result that cannot yet
	// be placed in the output register.
	assign advance  = !res_valid || !out_valid_q || out_ready;
	assign in_ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (in_ready)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= operation;
			byte_s1 <= rx_byte;
		end
	end

	ssr_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.word_valid (v_s1),
		.fire       (v_s1 && advance),
		.op         (op_s1),
		.rx         (byte_s1),
		.res_valid  (res_valid),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (v_s1 && advance && res_valid)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (v_s1 && advance && res_valid)
			out_q <= res;
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign resp_id     = out_q.resp_id;
	assign servo_error = out_q.servo_error;
	assign param_count = out_q.param_count;
	assign value       = out_q.value;

endmodule

FILE: sv/ssr_checker.sv
// Port-level checker for the servo status packet receiver, with its bind.
`include "servo_status_packet_receiver_macros.svh"

module ssr_checker import ssr_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic [2:0]       status,
	input logic [ByteW-1:0] servo_error,
	input logic [ByteW-1:0] param_count,
	input logic [15:0]      value
);

	// A stalled result word holds its status.
	`SSR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(status), "stalled result changed")

	// Only defined status codes leave the block.
	`SSR_ASSERT_NOW(a_status_code, out_valid, status <= ST_SERVO_ERR, "undefined status code")

	// A bad length ends the packet before the error byte and parameters.
	`SSR_ASSERT_NOW(a_bad_len_fields, out_valid && (status == ST_BAD_LENGTH),
		(servo_error == 8'd0) && (param_count == 8'd0) && (value == 16'd0),
		"bad length with captured fields")

	// Parameters not received leave their part of the value at zero.
	`SSR_ASSERT_NOW(a_value_fill, out_valid && (param_count < 8'd2),
		(value[15:8] == 8'd0) && ((param_count != 8'd0) || (value[7:0] == 8'd0)),
		"value holds unreceived parameters")

endmodule

bind servo_status_packet_receiver ssr_checker u_ssr_checker (.*);

FILE: bench/testbench.sv
// Self-checking testbench for the servo status packet receiver.
`timescale 1ns / 1ps

module testbench import ssr_pkg::*;;

	// Allow a comfortable margin after the last reply before a register write or
	// the final verdict.
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_PHASES = 7;
	localparam int WORDS_PER_PHASE = 200;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PRINT_CAP = 40;
	localparam int HOLD_AFTER_REPLIES = 20;
	localparam int HOLD_CYCLES = 600;

	// One word on the input channel.
	typedef struct packed {
		logic [1:0]       op;
		logic [ByteW-1:0] data;
	} bus_word_t;

	// Shadow copy of the receiver: it follows every accepted word, works out
	// the reply that a finished packet produces, and checks the replies that
	// the block hands out in the order they were predicted.
	class reply_scoreboard;
		cfg_t             regs;
		phase_t           phase;
		logic [ByteW-1:0] wait_count;
		logic [ByteW-1:0] got_id;
		logic [ByteW-1:0] got_length;
		logic [ByteW-1:0] got_error;
		logic [ByteW-1:0] param_index;
		logic [ByteW-1:0] running_sum;
		logic [15:0]      param_value;
		res_t             awaited_replies[$];
		int               errors;

		function new();
			regs.expected_id = RST_EXPECTED_ID;
			regs.retry_limit = RST_RETRY_LIMIT;
			regs.max_length = RST_MAX_LENGTH;
			phase = PH_IDLE;
			errors = 0;
			clear_packet();
		endfunction

		function void clear_packet();
			wait_count = '0;
			got_id = '0;
			got_length = '0;
			got_error = '0;
			param_index = '0;
			running_sum = '0;
			param_value = '0;
		endfunction

		function void set_register(logic [1:0] idx, logic [ByteW-1:0] data);
			case (idx)
				REG_EXPECTED_ID: regs.expected_id = data;
				REG_RETRY_LIMIT: regs.retry_limit = data;
				REG_MAX_LENGTH: regs.max_length = data;
				default: ;
			endcase
		endfunction

		function int pending();
			return awaited_replies.size();
		endfunction

		// A packet ends: the reply carries whatever has been captured so far.
		function void close_packet(logic [2:0] st);
			res_t r;
			r.status = st;
			r.resp_id = got_id;
			r.servo_error = got_error;
			r.param_count = param_index;
			r.value = param_value;
			awaited_replies.push_back(r);
			phase = PH_IDLE;
		endfunction

		function void take_word(logic [1:0] op, logic [ByteW-1:0] b);
			// A start always rearms, dropping any packet in progress.
			if (op == OP_START) begin
				clear_packet();
				phase = PH_HDR1;
				return;
			end
			if (phase == PH_IDLE || op == OP_NONE)
				return;
			if (op == OP_TICK) begin
				if (int'(wait_count) + 1 > int'(regs.retry_limit))
					close_packet(ST_TIMEOUT);
				else
					wait_count = wait_count + 8'd1;
				return;
			end
			case (phase)
				PH_HDR1: begin
					if (b == HEADER_BYTE)
						phase = PH_HDR2;
				end
				PH_HDR2: begin
					phase = (b == HEADER_BYTE) ? PH_ID : PH_HDR1;
				end
				PH_ID: begin
					got_id = b;
					running_sum = b;
					phase = PH_LEN;
				end
				PH_LEN: begin
					got_length = b;
					if (b < MIN_LENGTH || b > regs.max_length) begin
						close_packet(ST_BAD_LENGTH);
					end else begin
						running_sum = running_sum + b;
						wait_count = '0;
						phase = PH_ERR;
					end
				end
				PH_ERR: begin
					got_error = b;
					running_sum = running_sum + b;
					phase = (got_length == MIN_LENGTH) ? PH_SUM : PH_PARAM;
				end
				PH_PARAM: begin
					if (param_index == 8'd0)
						param_value[7:0] = b;
					else if (param_index == 8'd1)
						param_value[15:8] = b;
					running_sum = running_sum + b;
					param_index = param_index + 8'd1;
					if (int'(param_index) + 2 >= int'(got_length))
						phase = PH_SUM;
				end
				PH_SUM: begin
					// Checksum outranks the id check, which outranks the servo error.
					if (~running_sum != b)
						close_packet(ST_CHECKSUM);
					else if (got_id != regs.expected_id)
						close_packet(ST_ID);
					else if (got_error != 8'd0)
						close_packet(ST_SERVO_ERR);
					else
						close_packet(ST_OK);
				end
				default: ;
			endcase
		endfunction

		task report_mismatch(string what, int got, int want);
			errors++;
			if (errors <= PRINT_CAP)
				$display("%0t ns: reply mismatch on %s: got %0d, expected %0d",
					$time, what, got, want);
		endtask

		task check_reply(res_t got);
			res_t want;
			if (awaited_replies.size() == 0) begin
				report_mismatch("unexpected reply, status", got.status, -1);
				return;
			end
			want = awaited_replies.pop_front();
			if (got.status != want.status)
				report_mismatch("status", got.status, want.status);
			if (got.resp_id != want.resp_id)
				report_mismatch("resp_id", got.resp_id, want.resp_id);
			if (got.servo_error != want.servo_error)
				report_mismatch("servo_error", got.servo_error, want.servo_error);
			if (got.param_count != want.param_count)
				report_mismatch("param_count", got.param_count, want.param_count);
			if (got.value != want.value)
				report_mismatch("value", got.value, want.value);
		endtask
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [1:0]       operation = OP_NONE;
	logic [ByteW-1:0] rx_byte = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [2:0]       status;
	logic [ByteW-1:0] resp_id;
	logic [ByteW-1:0] servo_error;
	logic [ByteW-1:0] param_count;
	logic [15:0]      value;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [1:0]       cfg_index = REG_EXPECTED_ID;
	logic [ByteW-1:0] cfg_data = '0;

	reply_scoreboard sb = new();
	bus_word_t bus_words[$];
	int cycle_count = 0;

	servo_status_packet_receiver DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.resp_id(resp_id),
		.servo_error(servo_error),
		.param_count(param_count),
		.value(value),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Watchdog: a hung handshake must not leave the run spinning for ever.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Both channels are sampled at the rising edge, before any of this edge's
	// updates land, so every word is seen exactly as it was handed over.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.take_word(operation, rx_byte);
			if (out_valid && out_ready)
				sb.check_reply({status, resp_id, servo_error, param_count, value});
		end
	end

	// Result side back-pressure. The receiver switches between a handful of
	// stall patterns at random intervals, and once, after a few replies
	// have gone through, it refuses everything for a long stretch so that the
	// output register fills and the input channel is forced to stall as well.
	int  replies_taken = 0;
	int  hold_left = 0;
	int  mode_left = 0;
	int  stall_mode = 0;
	bit  hold_done = 1'b0;

	always @(posedge clk) begin
		if (out_valid && out_ready)
			replies_taken++;
		if (!hold_done && replies_taken >= HOLD_AFTER_REPLIES) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(50, 300);
		end
		mode_left--;
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= (mode_left % 4 == 0);
				default: out_ready <= (mode_left % 32 < 16);
			endcase
		end
	end

	function automatic void queue_word(logic [1:0] op, logic [ByteW-1:0] data);
		bus_word_t w;
		w.op = op;
		w.data = data;
		bus_words.push_back(w);
	endfunction

	// Builds one transaction: a start, then a status packet whose content,
	// length and faults are drawn at random. Some packets are cut short (the
	// next start then drops them), some are starved of bytes until the retry
	// limit runs out, and stray ticks, ignored words and broken headers are
	// sprinkled in along the way.
	function automatic void queue_transaction(cfg_t c);
		logic [ByteW-1:0] body[$];
		logic [ByteW-1:0] id;
		logic [ByteW-1:0] err;
		logic [ByteW-1:0] sum;
		logic [ByteW-1:0] pick;
		int len;
		int roll;
		int stop_at;
		int tick_at;
		roll = $urandom_range(0, 99);
		queue_word(OP_START, 8'($urandom_range(0, 255)));
		// Junk before the header is skipped while hunting for the first 0xFF.
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 3)) queue_word(OP_BYTE, 8'($urandom_range(0, 254)));
		// A header that breaks after its first byte sends the hunt back to the start.
		if ($urandom_range(0, 14) == 0) begin
			queue_word(OP_BYTE, HEADER_BYTE);
			queue_word(OP_BYTE, 8'($urandom_range(0, 254)));
		end
		id = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : c.expected_id;
		if (roll < 8) begin
			if (c.max_length == 8'hFF || $urandom_range(0, 1) == 0)
				len = $urandom_range(0, 1);
			else
				len = $urandom_range(int'(c.max_length) + 1, 255);
		end else if ($urandom_range(0, 19) == 0) begin
			len = $urandom_range(2, int'(c.max_length));
		end else begin
			len = $urandom_range(2, (c.max_length < 8'd9) ? int'(c.max_length) : 9);
		end
		body = '{HEADER_BYTE, HEADER_BYTE, id, 8'(len)};
		if (len >= 2 && len <= int'(c.max_length)) begin
			err = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
			sum = id + 8'(len) + err;
			body.push_back(err);
			for (int i = 0; i < len - 2; i++) begin
				pick = 8'($urandom_range(0, 255));
				sum = sum + pick;
				body.push_back(pick);
			end
			if ($urandom_range(0, 9) == 0)
				sum = sum ^ 8'($urandom_range(1, 255));
			body.push_back(~sum);
		end
		stop_at = (roll >= 8 && roll < 13) ? $urandom_range(0, body.size() - 1) : body.size();
		tick_at = (roll >= 13 && roll < 19) ? $urandom_range(0, body.size() - 1) : -1;
		foreach (body[i]) begin
			if (i == stop_at)
				break;
			if (i == tick_at) begin
				repeat (int'(c.retry_limit) + 1) queue_word(OP_TICK, 8'($urandom_range(0, 255)));
				break;
			end
			if ($urandom_range(0, 11) == 0)
				repeat ($urandom_range(1, 2)) queue_word(OP_TICK, 8'($urandom_range(0, 255)));
			if ($urandom_range(0, 39) == 0)
				queue_word(OP_NONE, 8'($urandom_range(0, 255)));
			queue_word(OP_BYTE, body[i]);
		end
	endfunction

	// Register settings for each random phase: the two extremes first, then the
	// reset values, then random mixes that favour short retry limits and
	// lengths so that timeouts and length faults stay common.
	function automatic cfg_t pick_setting(int p);
		cfg_t c;
		case (p)
			0: begin
				c.expected_id = 8'd0;
				c.retry_limit = 8'd0;
				c.max_length = MIN_LENGTH;
			end
			1: begin
				c.expected_id = 8'hFF;
				c.retry_limit = 8'hFF;
				c.max_length = 8'hFF;
			end
			2: begin
				c.expected_id = RST_EXPECTED_ID;
				c.retry_limit = RST_RETRY_LIMIT;
				c.max_length = RST_MAX_LENGTH;
			end
			default: begin
				c.expected_id = 8'($urandom_range(0, 255));
				c.retry_limit = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
					: 8'($urandom_range(0, 12));
				c.max_length = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(2, 255))
					: 8'($urandom_range(2, 16));
			end
		endcase
		return c;
	endfunction

	// Offers one word and holds it until the block takes it. Valid stays high
	// on return so that a following word can go out in the very next cycle.
	task automatic send_word(bus_word_t w);
		in_valid <= 1'b1;
		operation <= w.op;
		rx_byte <= w.data;
		do @(posedge clk); while (!in_ready);
	endtask

	// Sends every queued word in bursts of random length; a gap between bursts
	// is skipped now and then so that long unbroken runs also occur.
	task automatic run_words();
		int burst;
		int gap;
		while (bus_words.size() > 0) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && bus_words.size() > 0) begin
				send_word(bus_words.pop_front());
				burst--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
	endtask

	// Waits until every predicted reply has come back, then lets the block
	// settle in case the last words are still working through the pipeline.
	task automatic drain();
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [1:0] idx, logic [ByteW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(idx, data);
	endtask

	task automatic apply_settings(cfg_t c);
		write_register(REG_EXPECTED_ID, c.expected_id);
		write_register(REG_RETRY_LIMIT, c.retry_limit);
		write_register(REG_MAX_LENGTH, c.max_length);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		cfg_t setting;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, run with the reset register values (expected id 1).
		// Words that arrive while idle are ignored.
		queue_word(OP_NONE, 8'hA5);
		queue_word(OP_BYTE, HEADER_BYTE);
		queue_word(OP_TICK, 8'h00);
		// A clean packet with two parameters: expect ok and value 0x1234.
		queue_word(OP_START, 8'h00);
		queue_word(OP_BYTE, HEADER_BYTE);
		queue_word(OP_BYTE, HEADER_BYTE);
		queue_word(OP_BYTE, 8'h01);
		queue_word(OP_BYTE, 8'h04);
		queue_word(OP_BYTE, 8'h00);
		queue_word(OP_BYTE, 8'h34);
		queue_word(OP_BYTE, 8'h12);
		queue_word(OP_BYTE, 8'hB4);
		// A broken header restarts the hunt, then a length of one is refused.
		queue_word(OP_START, 8'hFF);
		queue_word(OP_BYTE, HEADER_BYTE);
		queue_word(OP_BYTE, 8'h00);
		queue_word(OP_BYTE, HEADER_BYTE);
		queue_word(OP_BYTE, HEADER_BYTE);
		queue_word(OP_BYTE, 8'h01);
		queue_word(OP_BYTE, 8'h01);
		// A start in mid-header drops that packet; the next one carries no
		// parameters and a servo error flag with a correct checksum.
		queue_word(OP_START, 8'h00);
		queue_word(OP_BYTE, HEADER_BYTE);
		queue_word(OP_START, 8'h00);
		queue_word(OP_BYTE, HEADER_BYTE);
		queue_word(OP_BYTE, HEADER_BYTE);
		queue_word(OP_BYTE, 8'h01);
		queue_word(OP_BYTE, 8'h02);
		queue_word(OP_BYTE, 8'h80);
		queue_word(OP_BYTE, 8'h7C);
		run_words();
		drain();

		// Random part: one register setting per phase, registers written only
		// once the block has gone quiet.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			setting = pick_setting(p);
			apply_settings(setting);
			while (bus_words.size() < WORDS_PER_PHASE) begin
				if ($urandom_range(0, 14) == 0)
					queue_word(2'($urandom_range(OP_BYTE, OP_NONE)), 8'($urandom_range(0, 255)));
				queue_transaction(setting);
			end
			run_words();
			drain();
		end

		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: servo_status_packet_receiver.f
+incdir+sv
sv/ssr_pkg.sv
sv/ssr_cfg_regs.sv
sv/ssr_parser.sv
sv/servo_status_packet_receiver.sv
sv/ssr_checker.sv
bench/testbench.sv
